// File: sv/wsp_pkg.sv
// Shared types and constants for the wheel speed PID controller.
package wsp_pkg;

    localparam int CNT_W     = 16;
    localparam int TGT_W     = 14;
    localparam int GAIN_W    = 16;
    localparam int SPEED_W   = 23;
    localparam int ERR_W     = 24;
    localparam int SUM_W     = 32;
    localparam int PWR_W     = 16;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int DIVD_W    = 34;
    localparam int CIDX_W    = 8;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd3072;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd205;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd1024;
    localparam logic [GAIN_W-1:0] DPC_RST    = 16'd1618;

    localparam logic [MUL_B_W-1:0] MS_PER_S   = 17'd1000;
    localparam logic [SPEED_W-1:0] SPEED_MAX  = 23'h7FFFFF;
    localparam logic [ACC_W-1:0]   ROUND_HALF = 51'd2048;
    localparam int                 ROUND_SH   = 12;
    localparam logic signed [PWR_W-1:0] POWER_LIMIT = 16'sd25600;

    typedef enum logic [CIDX_W-1:0] {
        REG_GAIN_P = 8'd0,
        REG_GAIN_I = 8'd1,
        REG_GAIN_D = 8'd2,
        REG_DPC    = 8'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DC,
        S_MUL_K,
        S_DIV_GO,
        S_DIV,
        S_ERR,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_ACC,
        S_PWR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

endpackage

// File: sv/wsp_div.sv
// Restoring divider for the speed quotient, one quotient bit per cycle.
module wsp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [wsp_pkg::DIVD_W-1:0]   i_dividend,
    input  logic [wsp_pkg::CNT_W-1:0]    i_divisor,
    output wsp_pkg::t_div_stat           o_stat,
    output logic [wsp_pkg::SPEED_W-1:0]  o_quotient
);

    localparam int QW = wsp_pkg::SPEED_W;
    localparam int DW = wsp_pkg::CNT_W;
    localparam int HW = wsp_pkg::DIVD_W - QW;

    logic          r_busy;
    logic          r_done;
    logic          r_ovf;
    logic [4:0]    r_cnt;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_bits;

    logic [HW-1:0] hi;
    logic          ovf;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign hi    = i_dividend[wsp_pkg::DIVD_W-1:QW];
    assign ovf   = {{(DW-HW){1'b0}}, hi} >= i_divisor;
    assign trial = {r_rem, r_bits[QW-1]};
    assign ge    = trial >= {1'b0, i_divisor};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_ovf <= ovf;
                if (ovf) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 5'(QW - 1);
                end
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {{(DW-HW){1'b0}}, hi};
            r_bits <= i_dividend[QW-1:0];
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_bits <= {r_bits[QW-2:0], ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;
    assign o_quotient  = r_bits;

endmodule

// File: sv/wheel_speed_pid.sv
// Incremental PID wheel speed controller, top level.
// The count and scale products are formed on one shared 33x17 signed
// multiplier. The S_DIV_GO step starts the restoring divider, which forms
// 23 quotient bits, one per cycle, and then hands the quotient over. The
// error update, the three gain products on the same multiplier, accumulate,
// round and clip, and the output load follow. A zero time delta skips the
// divide. A saturating speed makes the divider finish at once, without
// forming quotient bits. A restart item skips the computation and gives a
// zero result. The input is not ready while an item is in work. It is ready
// again in the cycle after the result is loaded. A finished result waits in
// the output register. While that register is still full, the next finished
// result holds the sequencer, and the input with it.
module wheel_speed_pid (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // encoder_count[15:0], time_ms[31:16],
                                        // target_speed[45:32], zero pad
    input  logic [0:0]  s_axis_tuser,   // restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // drive_power
    output logic [1:0]  m_axis_tuser,   // power_saturated, bad_interval
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CW = wsp_pkg::CNT_W;
    localparam int EW = wsp_pkg::ERR_W;
    localparam int SW = wsp_pkg::SUM_W;
    localparam int PW = wsp_pkg::PWR_W;
    localparam int AW = wsp_pkg::ACC_W;
    localparam int ROUND_SH_W = wsp_pkg::ROUND_SH;

    wsp_pkg::t_state r_state, n_state;

    logic [wsp_pkg::GAIN_W-1:0] r_gain_p, r_gain_i, r_gain_d, r_dpc;
    logic [CW-1:0]  r_last_count, r_last_time;
    logic [EW-1:0]  r_last_error;
    logic [SW-1:0]  r_error_sum;
    logic [PW-1:0]  r_power_acc;

    logic [CW-1:0]  r_dc, r_dt;
    logic [wsp_pkg::TGT_W-1:0] r_target;
    logic [wsp_pkg::SPEED_W-1:0] r_speed;
    logic           r_bad;
    logic [EW-1:0]  r_err;
    logic [EW:0]    r_derr;
    logic [SW-1:0]  r_sum;
    logic signed [wsp_pkg::PROD_W-1:0] r_mul;
    logic signed [AW-1:0] r_acc;
    logic [PW-1:0]  r_res_power;
    logic           r_res_sat, r_res_bad;
    logic           r_out_valid;
    logic [PW-1:0]  r_out_power;
    logic           r_out_sat, r_out_bad;

    logic           accept;
    logic           restart;
    logic [CW-1:0]  in_count, in_time;
    logic [wsp_pkg::TGT_W-1:0] in_target;
    logic           out_load;
    logic           mul_en;
    logic signed [wsp_pkg::MUL_A_W-1:0] mul_a;
    logic signed [wsp_pkg::MUL_B_W-1:0] mul_b;
    logic           div_start;
    wsp_pkg::t_div_stat div_stat;
    logic [wsp_pkg::SPEED_W-1:0] div_quo;

    logic [EW:0]    e_full;
    logic [EW-1:0]  err_c;
    logic [EW:0]    derr_c;
    logic [SW:0]    s_full;
    logic [SW-1:0]  sum_c;
    logic signed [AW-1:0] rnd;
    logic signed [AW-ROUND_SH_W-1:0] delta;
    logic signed [39:0] psum;
    logic [PW-1:0]  pwr_c;
    logic           sat_c;

    assign in_count  = s_axis_tdata[15:0];
    assign in_time   = s_axis_tdata[31:16];
    assign in_target = s_axis_tdata[45:32];
    assign restart   = s_axis_tuser[0];

    assign s_axis_tready = (r_state == wsp_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign out_load      = (r_state == wsp_pkg::S_DONE) && (!r_out_valid || m_axis_tready);
    assign div_start     = (r_state == wsp_pkg::S_DIV_GO) && (r_dt != '0);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            wsp_pkg::S_IDLE: begin
                if (accept) n_state = restart ? wsp_pkg::S_DONE : wsp_pkg::S_MUL_DC;
            end
            wsp_pkg::S_MUL_DC: n_state = wsp_pkg::S_MUL_K;
            wsp_pkg::S_MUL_K:  n_state = wsp_pkg::S_DIV_GO;
            wsp_pkg::S_DIV_GO: n_state = (r_dt == '0) ? wsp_pkg::S_ERR : wsp_pkg::S_DIV;
            wsp_pkg::S_DIV: begin
                if (div_stat.done) n_state = wsp_pkg::S_ERR;
            end
            wsp_pkg::S_ERR:   n_state = wsp_pkg::S_MUL_P;
            wsp_pkg::S_MUL_P: n_state = wsp_pkg::S_MUL_I;
            wsp_pkg::S_MUL_I: n_state = wsp_pkg::S_MUL_D;
            wsp_pkg::S_MUL_D: n_state = wsp_pkg::S_ACC;
            wsp_pkg::S_ACC:   n_state = wsp_pkg::S_PWR;
            wsp_pkg::S_PWR:   n_state = wsp_pkg::S_DONE;
            wsp_pkg::S_DONE: begin
                if (out_load) n_state = wsp_pkg::S_IDLE;
            end
            default: n_state = wsp_pkg::S_IDLE;
        endcase
    end

    // shared multiplier operands
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            wsp_pkg::S_MUL_DC: begin
                mul_a = {17'd0, r_dc};
                mul_b = {1'b0, r_dpc};
            end
            wsp_pkg::S_MUL_K: begin
                mul_a = {1'b0, r_mul[31:0]};
                mul_b = wsp_pkg::MS_PER_S;
            end
            wsp_pkg::S_MUL_P: begin
                mul_a = {{9{r_err[EW-1]}}, r_err};
                mul_b = {1'b0, r_gain_p};
            end
            wsp_pkg::S_MUL_I: begin
                mul_a = {r_sum[SW-1], r_sum};
                mul_b = {1'b0, r_gain_i};
            end
            wsp_pkg::S_MUL_D: begin
                mul_a = {{8{r_derr[EW]}}, r_derr};
                mul_b = {1'b0, r_gain_d};
            end
            default: mul_en = 1'b0;
        endcase
    end

    // error, error change and saturating error sum
    always_comb begin
        e_full = {{(EW+1-wsp_pkg::TGT_W){r_target[wsp_pkg::TGT_W-1]}}, r_target}
                 - {2'b00, r_speed};
        if (e_full[EW] != e_full[EW-1]) begin
            err_c = e_full[EW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
        end else begin
            err_c = e_full[EW-1:0];
        end
        derr_c = {err_c[EW-1], err_c} - {r_last_error[EW-1], r_last_error};
        s_full = {r_error_sum[SW-1], r_error_sum} + {{(SW+1-EW){err_c[EW-1]}}, err_c};
        if (s_full[SW] != s_full[SW-1]) begin
            sum_c = s_full[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sum_c = s_full[SW-1:0];
        end
    end

    // rounding to Q8.8 and power clip
    always_comb begin
        rnd   = r_acc + wsp_pkg::ROUND_HALF;
        delta = rnd[AW-1:ROUND_SH_W];
        psum  = {{(40-PW){r_power_acc[PW-1]}}, r_power_acc}
                + {{(40-(AW-ROUND_SH_W)){delta[AW-ROUND_SH_W-1]}}, delta};
        sat_c = 1'b1;
        if (psum > 40'sd25600) begin
            pwr_c = wsp_pkg::POWER_LIMIT;
        end else if (psum < -40'sd25600) begin
            pwr_c = -wsp_pkg::POWER_LIMIT;
        end else begin
            pwr_c = psum[PW-1:0];
            sat_c = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= wsp_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_gain_p     <= wsp_pkg::GAIN_P_RST;
            r_gain_i     <= wsp_pkg::GAIN_I_RST;
            r_gain_d     <= wsp_pkg::GAIN_D_RST;
            r_dpc        <= wsp_pkg::DPC_RST;
            r_last_count <= '0;
            r_last_time  <= '0;
            r_last_error <= '0;
            r_error_sum  <= '0;
            r_power_acc  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    wsp_pkg::REG_GAIN_P: r_gain_p <= i_cfg_data;
                    wsp_pkg::REG_GAIN_I: r_gain_i <= i_cfg_data;
                    wsp_pkg::REG_GAIN_D: r_gain_d <= i_cfg_data;
                    wsp_pkg::REG_DPC:    r_dpc    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                if (restart) begin
                    r_last_count <= '0;
                    r_last_time  <= in_time;
                    r_last_error <= '0;
                    r_error_sum  <= '0;
                    r_power_acc  <= '0;
                end else begin
                    r_last_count <= in_count;
                    r_last_time  <= in_time;
                end
            end
            if (r_state == wsp_pkg::S_ERR) begin
                r_last_error <= err_c;
                r_error_sum  <= sum_c;
            end
            if (r_state == wsp_pkg::S_PWR) begin
                r_power_acc <= pwr_c;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dc        <= in_count - r_last_count;
            r_dt        <= in_time - r_last_time;
            r_target    <= in_target;
            r_bad       <= 1'b0;
            r_res_power <= '0;
            r_res_sat   <= 1'b0;
            r_res_bad   <= 1'b0;
        end
        if (mul_en) begin
            r_mul <= mul_a * mul_b;
        end
        if ((r_state == wsp_pkg::S_DIV_GO) && (r_dt == '0)) begin
            r_speed <= '0;
            r_bad   <= 1'b1;
        end
        if ((r_state == wsp_pkg::S_DIV) && div_stat.done) begin
            r_speed <= div_stat.ovf ? wsp_pkg::SPEED_MAX : div_quo;
        end
        if (r_state == wsp_pkg::S_ERR) begin
            r_err  <= err_c;
            r_derr <= derr_c;
            r_sum  <= sum_c;
        end
        if (r_state == wsp_pkg::S_MUL_I) begin
            r_acc <= {r_mul[wsp_pkg::PROD_W-1], r_mul};
        end else if ((r_state == wsp_pkg::S_MUL_D) || (r_state == wsp_pkg::S_ACC)) begin
            r_acc <= r_acc + {r_mul[wsp_pkg::PROD_W-1], r_mul};
        end
        if (r_state == wsp_pkg::S_PWR) begin
            r_res_power <= pwr_c;
            r_res_sat   <= sat_c;
            r_res_bad   <= r_bad;
        end
        if (out_load) begin
            r_out_power <= r_res_power;
            r_out_sat   <= r_res_sat;
            r_out_bad   <= r_res_bad;
        end
    end

    wsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_mul[41:8]),
        .i_divisor  (r_dt),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_power;
    assign m_axis_tuser  = {r_out_bad, r_out_sat};

    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($signed(r_out_power) <= wsp_pkg::POWER_LIMIT)
                     && ($signed(r_out_power) >= -wsp_pkg::POWER_LIMIT))
        else $error("drive power outside limit");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |-> ($signed(r_out_power) == wsp_pkg::POWER_LIMIT)
                                    || ($signed(r_out_power) == -wsp_pkg::POWER_LIMIT))
        else $error("saturation flag without power at a limit");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == wsp_pkg::S_DIV))
        else $error("divider finished outside divide step");

    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !restart) |=> (r_state == wsp_pkg::S_MUL_DC))
        else $error("sample transfer did not start the sequence");

endmodule

// File: tb/wsp_power_checker.sv
// Transfer monitor, drive power predictor and result comparison for wheel_speed_pid.
module wsp_power_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [47:0] i_in_data,    // encoder_count[15:0], time_ms[31:16],
                                      // target_speed[45:32], zero pad
    input  logic [0:0]  i_in_user,    // restart
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,   // drive_power
    input  logic [1:0]  i_out_user,   // power_saturated, bad_interval
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [wsp_pkg::PWR_W-1:0] power;
        logic                             sat;
        logic                             bad;
    } t_power_out;

    logic [wsp_pkg::GAIN_W-1:0]       kp_reg, ki_reg, kd_reg, dpc_reg;
    logic [wsp_pkg::CNT_W-1:0]        prev_count, prev_stamp;
    logic signed [wsp_pkg::ERR_W-1:0] prev_err;
    logic signed [wsp_pkg::SUM_W-1:0] err_total;
    logic signed [wsp_pkg::ERR_W-1:0] power_now;

    t_power_out power_due[$];
    int         fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = power_due.size();

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fails++;
    endtask

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advances the controller state by one sample and returns the drive power it yields.
    function automatic t_power_out next_power(input logic restart, input logic [15:0] cnt,
                                              input logic [15:0] stamp,
                                              input logic signed [13:0] tgt);
        logic [wsp_pkg::CNT_W-1:0] dc, dt;
        longint unsigned   num, quot;
        longint            speed, err, derr, sum, delta, pwr, kp, ki, kd;
        t_power_out        r;
        r = '0;
        if (restart) begin
            prev_count = '0;
            prev_stamp = stamp;
            prev_err   = '0;
            err_total  = '0;
            power_now  = '0;
            return r;
        end
        dc = cnt - prev_count;
        dt = stamp - prev_stamp;
        prev_count = cnt;
        prev_stamp = stamp;
        if (dt == '0) begin
            r.bad = 1'b1;
            speed = 0;
        end else begin
            num   = dc;
            num   = num * dpc_reg * wsp_pkg::MS_PER_S;
            quot  = num / ({48'd0, dt} * 256);
            speed = (quot > wsp_pkg::SPEED_MAX) ? wsp_pkg::SPEED_MAX : quot;
        end
        err   = clip(longint'(tgt) - speed, -(64'sd1 <<< 23), (64'sd1 <<< 23) - 1);
        derr  = err - longint'(prev_err);
        prev_err = err[wsp_pkg::ERR_W-1:0];
        sum   = clip(longint'(err_total) + err, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
        err_total = sum[wsp_pkg::SUM_W-1:0];
        kp    = kp_reg;
        ki    = ki_reg;
        kd    = kd_reg;
        delta = (err * kp + sum * ki + derr * kd + 2048) >>> wsp_pkg::ROUND_SH;
        pwr   = longint'(power_now) + delta;
        if (pwr > longint'(wsp_pkg::POWER_LIMIT)) begin
            pwr   = wsp_pkg::POWER_LIMIT;
            r.sat = 1'b1;
        end else if (pwr < -longint'(wsp_pkg::POWER_LIMIT)) begin
            pwr   = -longint'(wsp_pkg::POWER_LIMIT);
            r.sat = 1'b1;
        end
        power_now = pwr[wsp_pkg::ERR_W-1:0];
        r.power   = pwr[wsp_pkg::PWR_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_power_out due;
        if (!i_rst_n) begin
            kp_reg     = wsp_pkg::GAIN_P_RST;
            ki_reg     = wsp_pkg::GAIN_I_RST;
            kd_reg     = wsp_pkg::GAIN_D_RST;
            dpc_reg    = wsp_pkg::DPC_RST;
            prev_count = '0;
            prev_stamp = '0;
            prev_err   = '0;
            err_total  = '0;
            power_now  = '0;
            power_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (power_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing expected",
                                              $signed(i_out_data)));
                end else begin
                    due = power_due.pop_front();
                    if (i_out_data !== due.power)
                        report_mismatch($sformatf("drive_power %0d, expected %0d",
                                                  $signed(i_out_data), due.power));
                    if (i_out_user[0] !== due.sat)
                        report_mismatch($sformatf("power_saturated %b, expected %b",
                                                  i_out_user[0], due.sat));
                    if (i_out_user[1] !== due.bad)
                        report_mismatch($sformatf("bad_interval %b, expected %b",
                                                  i_out_user[1], due.bad));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    wsp_pkg::REG_GAIN_P: kp_reg  = i_cfg_data;
                    wsp_pkg::REG_GAIN_I: ki_reg  = i_cfg_data;
                    wsp_pkg::REG_GAIN_D: kd_reg  = i_cfg_data;
                    wsp_pkg::REG_DPC:    dpc_reg = i_cfg_data;
                    default:    ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                power_due.push_back(next_power(i_in_user[0], i_in_data[15:0],
                                               i_in_data[31:16], i_in_data[45:32]));
        end
    end

endmodule

// File: tb/tb.sv
// Stimulus, handshake pacing and verdict for the wheel_speed_pid regression.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0]  REG_SPARE = 8'd4;
    localparam logic [7:0]  REG_TOP   = 8'hFF;
    localparam logic [13:0] TGT_MAX   = 14'h1FFF;
    localparam logic [13:0] TGT_MIN   = 14'h2000;
    localparam logic [15:0] ALL_ONES  = 16'hFFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    int          fail_count;
    int          pending;
    bit          calm = 1'b0;
    int          hold_asked = 0;
    int          hold_served = 0;
    logic [15:0] enc_pos = '0;
    logic [15:0] stamp_ms = '0;

    wheel_speed_pid uut (.*);

    wsp_power_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("wheel_speed_pid regression: fail");
        $finish;
    end

    function automatic int pause_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int len;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                len = pause_len();
                m_axis_tready <= 1'b0;
                repeat (len - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic restart, input logic [15:0] cnt,
                               input logic [15:0] stamp, input logic [13:0] tgt);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, tgt, stamp, cnt};
        s_axis_tuser  <= restart;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        enc_pos  = restart ? 16'd0 : cnt;
        stamp_ms = stamp;
        if (!calm && $urandom_range(0, 2) == 0) begin
            gap = pause_len();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // mostly plausible motion, some restarts, stalled clocks and pure noise
    task automatic random_item();
        int          roll;
        logic [13:0] tgt;
        roll = $urandom_range(0, 99);
        tgt  = ($urandom_range(0, 1) == 1) ? 14'($urandom)
                                           : 14'(int'($urandom_range(0, 2048)) - 512);
        if (roll < 3)
            send_sample(1'b1, 16'($urandom), stamp_ms + 16'($urandom_range(0, 500)), tgt);
        else if (roll < 10)
            send_sample(1'b0, 16'($urandom), 16'($urandom), 14'($urandom));
        else if (roll < 14)
            send_sample(1'b0, enc_pos + 16'($urandom_range(0, 300)), stamp_ms, tgt);
        else
            send_sample(1'b0, enc_pos + 16'($urandom_range(0, 300)),
                        stamp_ms + 16'($urandom_range(1, 250)), tgt);
    endtask

    // input held off until every result is back, then a short quiet spell
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_gains(input logic [15:0] kp, input logic [15:0] ki,
                              input logic [15:0] kd, input logic [15:0] dpc);
        write_reg(wsp_pkg::REG_GAIN_P, kp);
        write_reg(wsp_pkg::REG_GAIN_I, ki);
        write_reg(wsp_pkg::REG_GAIN_D, kd);
        write_reg(wsp_pkg::REG_DPC, dpc);
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero interval, restarts, wraps, extremes, power clipping both ways
        send_sample(1'b0, 16'd0, 16'd0, 14'd0);
        send_sample(1'b1, ALL_ONES, 16'd100, TGT_MAX);
        send_sample(1'b0, 16'd50, 16'd200, 14'd5000);
        send_sample(1'b0, 16'd10, 16'd300, TGT_MAX);
        for (int k = 1; k <= 5; k++)
            send_sample(1'b0, 16'd10, 16'(300 + k), TGT_MAX);
        send_sample(1'b0, 16'd10, 16'd305, TGT_MIN);
        for (int k = 1; k <= 5; k++)
            send_sample(1'b0, 16'd10, 16'(305 + k), TGT_MIN);
        send_sample(1'b0, ALL_ONES, ALL_ONES, TGT_MIN);
        send_sample(1'b0, 16'hFFFE, 16'd0, 14'd0);
        send_sample(1'b0, 16'h7FFF, 16'd1, TGT_MIN);
        send_sample(1'b1, 16'd0, ALL_ONES, 14'd0);
        send_sample(1'b0, ALL_ONES, 16'hFFFE, TGT_MAX);
        send_sample(1'b0, ALL_ONES, 16'hFFFE, 14'h3FFF);

        for (int p = 0; p < 7; p++) begin
            settle();
            case (p)
                0: begin
                    write_reg(REG_SPARE, ALL_ONES);
                    write_reg(REG_TOP, 16'd0);
                end
                1: load_gains(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
                2: load_gains(16'd0, 16'd0, 16'd0, 16'd0);
                3: load_gains(16'd0, ALL_ONES, 16'd0, 16'd1);
                4, 5: load_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                default: load_gains(wsp_pkg::GAIN_P_RST, wsp_pkg::GAIN_I_RST,
                                    wsp_pkg::GAIN_D_RST, wsp_pkg::DPC_RST);
            endcase
            // overspeed run drives the error sum into its negative limit
            if (p == 0)
                for (int k = 0; k < 280; k++)
                    send_sample(1'b0, enc_pos + 16'($urandom_range(40000, 65535)),
                                stamp_ms + 16'($urandom_range(1, 5)),
                                TGT_MIN + 14'($urandom_range(0, 50)));
            calm = (p == 4);
            for (int k = 0; k < 110; k++) begin
                if (p == 4 && k == 55) calm = 1'b0;
                if (p == 5 && k == 20) hold_asked++;
                if (p == 3 && k == 60) settle();
                random_item();
            end
        end
        settle();
        repeat (60) @(negedge i_clk);

        if (fail_count == 0)
            $display("wheel_speed_pid regression: pass");
        else
            $display("wheel_speed_pid regression: fail");
        $finish;
    end

endmodule
